@@ rtl/rpfs_pkg.sv @@
// ----------------------------------------------------------------------------
// rpfs_pkg
// Shared constants, widths, codes and controller/datapath interface types for
// the rate-paced flow sender.
// ----------------------------------------------------------------------------
package rpfs_pkg;

    localparam int HDR_BYTES  = 40;
    localparam int NS_PER_SEC = 1000000000;

    localparam int OP_W       = 2;
    localparam int TYPE_W     = 3;
    localparam int TIME_W     = 64;
    localparam int SEQ_W      = 32;
    localparam int RATE_IN_W  = 32;
    localparam int FP_W       = 32;
    localparam int PAY_W      = 16;
    localparam int SUM_W      = PAY_W + 1;
    localparam int NS_W       = 30;
    localparam int NUM_W      = NS_W + SUM_W;
    localparam int RATE_W     = RATE_IN_W - 1;
    localparam int INTV_W     = 48;
    localparam int DCNT_W     = $clog2(NUM_W);

    localparam int IN_TDATA_W  = 200;
    localparam int OUT_TDATA_W = 104;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 32;

    localparam logic [NS_W-1:0]  NS_CONST  = NS_W'(NS_PER_SEC);
    localparam logic [SUM_W-1:0] HDR_CONST = SUM_W'(HDR_BYTES);

    // config register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_FLOW_PACKETS  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_BYTES = 1'b1;
    localparam logic [FP_W-1:0]      FLOW_PKTS_RST     = 32'd10000;
    localparam logic [PAY_W-1:0]     PAYLOAD_RST       = 16'd960;

    typedef enum logic [OP_W-1:0] {
        OP_START = 2'd0,
        OP_TIME  = 2'd1,
        OP_RX    = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [TYPE_W-1:0] {
        PK_SYN     = 3'd0,
        PK_SYNACK  = 3'd1,
        PK_DATA    = 3'd2,
        PK_ACK     = 3'd3,
        PK_FIN     = 3'd4,
        PK_FINACK  = 3'd5,
        PK_OTHER   = 3'd6,
        PK_UNKNOWN = 3'd7
    } t_pkt;

    typedef struct packed {
        logic capture;
        logic prep;
        logic eval;
        logic mul;
        logic div_start;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic need_div;
        logic div_done;
    } t_dp_status;

endpackage

@@ rtl/rate_paced_flow_sender_core.sv @@
// ----------------------------------------------------------------------------
// rate_paced_flow_sender_core
// Sender side of a rate-paced flow: events in, one send decision out.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser = opcode (start, time check, packet received),
//   tdata = current time, received type, rate, ack number and echo time.
//   Master stream: one result per accepted item (send flag, type, sequence
//   number, RTT, flow-done and rate-error flags).
//   Config port: write flow_packets (index 0) or payload_bytes (index 1)
//   while the block is idle; takes effect on the next item.
//   Items are handled one at a time: an accepted item is captured, its time
//   differences are prepared, then it is evaluated and loaded for output.
//   A grant with a positive rate also computes the interval: it goes
//   through a multiply and a 47-step restoring divider, one bit per cycle.
//   A finished result sits in the output register; the next item is taken
//   meanwhile and its result waits until the register frees up.
//   Reset (synchronous, active low) clears flow state, interval, counters
//   and restores the config defaults (10000 packets, 960 payload bytes).
// ----------------------------------------------------------------------------
module rate_paced_flow_sender_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rpfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rpfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [1:0] opcode
    input  logic [rpfs_pkg::OP_W-1:0]        s_axis_tuser,
    // now_time[63:0], rx_type[66:64], rx_rate[98:67], rx_ack_number[130:99],
    // rx_echo_time[194:131], zero pad
    input  logic [rpfs_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // send_valid[0], send_type[3:1], send_seq[35:4], send_rtt[99:36],
    // flow_done[100], rate_error[101], zero pad
    output logic [rpfs_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rpfs_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    rpfs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    rpfs_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_s_tuser   (s_axis_tuser),
        .i_s_tdata   (s_axis_tdata),
        .o_m_tdata   (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // one item in flight: no accept right after an accept
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while previous item in flight");

    // no send means zero type, sequence and RTT
    a_nosend_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[99:1] == '0))
        else $error("send fields nonzero without a send");

    // a rate error is only reported on a grant, which never sends
    a_err_nosend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[101] && m_axis_tdata[0]))
        else $error("rate error together with a send");
`endif

endmodule

@@ rtl/rpfs_div.sv @@
// ----------------------------------------------------------------------------
// rpfs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rpfs_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rpfs_pkg::NUM_W-1:0]  i_num,
    input  logic [rpfs_pkg::RATE_W-1:0] i_den,
    output logic                       o_done,
    output logic [rpfs_pkg::NUM_W-1:0]  o_quot
);
    import rpfs_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_den;
    logic [NUM_W-1:0]  r_num;

    logic [RATE_W:0]   trial;
    logic              ge;
    logic [RATE_W:0]   diff;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = trial >= {1'b0, r_den};
    assign diff  = trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(NUM_W - 1);
                r_rem  <= '0;
                r_num  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                // remainder stays below the divisor, so it fits RATE_W bits
                r_rem <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
                r_num <= {r_num[NUM_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

@@ rtl/rpfs_dp.sv @@
// ----------------------------------------------------------------------------
// rpfs_dp
// Datapath: item capture, flow state, time and RTT arithmetic, interval
// multiply/divide and the result register.
// ----------------------------------------------------------------------------
module rpfs_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rpfs_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [rpfs_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  rpfs_pkg::t_ctrl_cmd             i_cmd,
    output rpfs_pkg::t_dp_status            o_status,
    input  logic [rpfs_pkg::OP_W-1:0]        i_s_tuser,
    input  logic [rpfs_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    output logic [rpfs_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import rpfs_pkg::*;

    typedef enum logic [2:0] {
        FS_INACTIVE = 3'd0,
        FS_SYNSENT  = 3'd1,
        FS_RUNNING  = 3'd2,
        FS_CONGEST  = 3'd3,
        FS_FINSENT  = 3'd4,
        FS_DONE     = 3'd5
    } t_flow;

    // configuration
    logic [FP_W-1:0]   r_flow_pkts;
    logic [PAY_W-1:0]  r_payload;

    // captured item
    t_op                  r_op;
    t_pkt                 r_type;
    logic [TIME_W-1:0]    r_now;
    logic [RATE_IN_W-1:0] r_rate;
    logic [SEQ_W-1:0]     r_ack;
    logic [TIME_W-1:0]    r_echo;

    // precomputed differences
    logic [TIME_W-1:0] r_diff;
    logic              r_tge;
    logic [TIME_W-1:0] r_rtt;

    // flow state
    t_flow             r_flow;
    logic              r_over;
    logic [SEQ_W-1:0]  r_seq;
    logic [SEQ_W-1:0]  r_exp;
    logic [TIME_W-1:0] r_round;
    logic [INTV_W-1:0] r_intv;
    logic [TIME_W-1:0] r_last;
    logic [SEQ_W-1:0]  r_pkts;

    logic [NUM_W-1:0]       r_prod;
    logic [OUT_TDATA_W-1:0] r_res;
    logic [OUT_TDATA_W-1:0] r_m_tdata;

    // next values from the evaluate step
    t_flow             n_flow;
    logic              n_over;
    logic [SEQ_W-1:0]  n_seq;
    logic [SEQ_W-1:0]  n_exp;
    logic [TIME_W-1:0] n_round;
    logic [TIME_W-1:0] n_last;
    logic [SEQ_W-1:0]  n_pkts;
    logic [OUT_TDATA_W-1:0] n_res;

    logic              emit;
    t_pkt              emit_type;
    logic [TIME_W-1:0] emit_rtt;
    logic              res_done;
    logic              res_err;
    logic              rate_pos;
    logic              time_ok;
    logic              pkts_more;
    logic [SEQ_W-1:0]  ack_sat;
    logic [SUM_W-1:0]  byte_sum;
    logic [NUM_W-1:0]  prod_c;
    logic              div_done;
    logic [NUM_W-1:0]  div_quot;

    assign rate_pos  = (r_rate != '0) && !r_rate[RATE_IN_W-1];
    assign time_ok   = r_tge && (r_diff >= TIME_W'(r_intv));
    assign pkts_more = ({1'b0, r_pkts} + (SEQ_W+1)'(1)) < {1'b0, r_flow_pkts};
    assign ack_sat   = (r_ack == '1) ? r_ack : r_ack + 1'b1;
    assign byte_sum  = {1'b0, r_payload} + HDR_CONST;
    assign prod_c    = NUM_W'(NS_CONST) * NUM_W'(byte_sum);

    always_comb begin
        n_flow    = r_flow;
        n_over    = r_over;
        n_seq     = r_seq;
        n_exp     = r_exp;
        n_round   = r_round;
        n_last    = r_last;
        n_pkts    = r_pkts;
        emit      = 1'b0;
        emit_type = PK_SYN;
        emit_rtt  = r_round;
        res_done  = 1'b0;
        res_err   = 1'b0;
        if (r_flow == FS_DONE) begin
            res_done = 1'b1;
        end else begin
            case (r_op)
                OP_START: begin
                    if (r_flow == FS_INACTIVE) begin
                        n_last    = r_now;
                        emit      = 1'b1;
                        emit_type = PK_SYN;
                        n_flow    = FS_SYNSENT;
                        n_pkts    = r_pkts + 1'b1;
                    end
                end
                OP_TIME: begin
                    if (r_flow == FS_RUNNING && !r_over && time_ok) begin
                        n_last = r_now;
                        emit   = 1'b1;
                        if (pkts_more) begin
                            emit_type = PK_DATA;
                        end else begin
                            emit_type = PK_FIN;
                            n_flow    = FS_FINSENT;
                            n_over    = 1'b1;
                        end
                        n_pkts = r_pkts + 1'b1;
                    end
                end
                OP_RX: begin
                    if (ack_sat > r_exp) begin
                        n_exp = ack_sat;
                    end
                    n_round  = r_rtt;
                    emit_rtt = r_rtt;
                    case (r_type)
                        PK_SYNACK, PK_ACK: begin
                            if (rate_pos) begin
                                if (r_type == PK_SYNACK || r_flow == FS_CONGEST) begin
                                    n_flow = FS_RUNNING;
                                end
                            end else begin
                                n_flow  = FS_CONGEST;
                                res_err = 1'b1;
                            end
                        end
                        PK_SYN: begin
                            emit      = 1'b1;
                            emit_type = PK_SYNACK;
                        end
                        PK_DATA: begin
                            emit      = 1'b1;
                            emit_type = PK_ACK;
                        end
                        PK_FIN: begin
                            emit      = 1'b1;
                            emit_type = PK_FINACK;
                        end
                        PK_FINACK: begin
                            n_flow   = FS_DONE;
                            n_over   = 1'b1;
                            res_done = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
        if (emit) begin
            n_seq = r_seq + 1'b1;
        end
        // result layout, low bit up: valid, type, seq, rtt, done, error, pad
        n_res = {2'b00, res_err, res_done,
                 emit ? emit_rtt : '0,
                 emit ? r_seq : '0,
                 emit ? emit_type : PK_SYN,
                 emit};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flow_pkts <= FLOW_PKTS_RST;
            r_payload   <= PAYLOAD_RST;
            r_flow      <= FS_INACTIVE;
            r_over      <= 1'b0;
            r_seq       <= '0;
            r_exp       <= '0;
            r_round     <= '0;
            r_intv      <= '0;
            r_last      <= '0;
            r_pkts      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_FLOW_PACKETS:  r_flow_pkts <= i_cfg_wdata[FP_W-1:0];
                    REG_PAYLOAD_BYTES: r_payload   <= i_cfg_wdata[PAY_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.eval) begin
                r_flow  <= n_flow;
                r_over  <= n_over;
                r_seq   <= n_seq;
                r_exp   <= n_exp;
                r_round <= n_round;
                r_last  <= n_last;
                r_pkts  <= n_pkts;
            end
            if (div_done) begin
                r_intv <= INTV_W'(div_quot);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_s_tuser);
            r_now  <= i_s_tdata[63:0];
            r_type <= t_pkt'(i_s_tdata[66:64]);
            r_rate <= i_s_tdata[98:67];
            r_ack  <= i_s_tdata[130:99];
            r_echo <= i_s_tdata[194:131];
        end
        if (i_cmd.prep) begin
            r_tge  <= r_now >= r_last;
            r_diff <= r_now - r_last;
            r_rtt  <= (r_now >= r_echo) ? r_now - r_echo : '0;
        end
        if (i_cmd.eval) begin
            r_res <= n_res;
        end
        if (i_cmd.mul) begin
            r_prod <= prod_c;
        end
        if (i_cmd.load_out) begin
            r_m_tdata <= r_res;
        end
    end

    rpfs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_rate[RATE_W-1:0]),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_status.need_div = (r_flow != FS_DONE) && (r_op == OP_RX) && rate_pos &&
                               (r_type == PK_SYNACK || r_type == PK_ACK);
    assign o_status.div_done = div_done;
    assign o_m_tdata         = r_m_tdata;

endmodule

@@ rtl/rpfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpfs_ctrl
// Sequencer: accepts one item, steps the datapath through evaluation and the
// optional interval division, then hands the result to the output register.
// ----------------------------------------------------------------------------
module rpfs_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output rpfs_pkg::t_ctrl_cmd   o_cmd,
    input  rpfs_pkg::t_dp_status  i_status
);
    import rpfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_EVAL,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;
    logic   r_m_tvalid;
    logic   out_free;

    assign out_free = !r_m_tvalid || i_m_tready;

    always_comb begin
        o_cmd.capture   = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.prep      = (r_state == S_PREP);
        o_cmd.eval      = (r_state == S_EVAL);
        o_cmd.mul       = (r_state == S_MUL);
        o_cmd.div_start = (r_state == S_DSTART);
        o_cmd.load_out  = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_m_tvalid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE:   if (i_s_tvalid) r_state <= S_PREP;
                S_PREP:   r_state <= S_EVAL;
                S_EVAL:   r_state <= i_status.need_div ? S_MUL : S_OUT;
                S_MUL:    r_state <= S_DSTART;
                S_DSTART: r_state <= S_DIV;
                S_DIV:    if (i_status.div_done) r_state <= S_OUT;
                S_OUT:    if (out_free) r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_tvalid;

endmodule
